/* src/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants for the bounded set/list table: command and
// status codes, fixed field widths and the configuration register map.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // Fixed widths of the channel fields.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // Default sizing of the entry store.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ENTRY_BITS  = 32;

    // Configuration port geometry and register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_NONE     = 1'b1
    } reg_index_t;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UNION  = 2'd3
    } cmd_code_t;

    // Status returned with each result item.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERRUN = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

endpackage

/* src/bsl_if.sv */
// ----------------------------------------------------------------------------
// bsl_if
// Valid/ready channels of the table: the command channel and the result
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------

// Command channel: one item per table command.
interface bsl_cmd_if;
    logic                           valid;
    logic                           ready;
    bsl_pkg::cmd_code_t             command;
    logic [bsl_pkg::VALUE_W-1:0]    item_value;
    logic [bsl_pkg::POS_W-1:0]      position;
    logic                           batch_start;

    modport source (
        output valid, command, item_value, position, batch_start,
        input  ready
    );
    modport sink (
        input  valid, command, item_value, position, batch_start,
        output ready
    );
endinterface

// Result channel: one item per accepted command.
interface bsl_rsp_if;
    logic                           valid;
    logic                           ready;
    bsl_pkg::status_t               status;
    logic [bsl_pkg::COUNT_W-1:0]    entry_count;
    logic                           was_present;

    modport source (
        output valid, status, entry_count, was_present,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, was_present,
        output ready
    );
endinterface

/* src/bsl_ram.sv */
// ----------------------------------------------------------------------------
// bsl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bsl_cfg.sv */
// ----------------------------------------------------------------------------
// bsl_cfg
// APB-style configuration port holding the capacity register.
// ----------------------------------------------------------------------------
module bsl_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsl_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bsl_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bsl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [bsl_pkg::COUNT_W-1:0]         capacity
);
    import bsl_pkg::*;

    logic [COUNT_W-1:0] capacity_reg;
    logic [COUNT_W-1:0] capacity_next;
    reg_index_t         reg_sel;
    logic               wr_strobe;

    // Registers sit on 32-bit word boundaries.
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register write decode.
    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_strobe && reg_sel == REG_CAPACITY)
        begin
            capacity_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read data mux.
    always_comb
    begin
        case (reg_sel)
            REG_CAPACITY: prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, capacity_reg};
            default:      prdata = '0;
        endcase
    end

    assign capacity = capacity_reg;

endmodule

/* src/bsl_ctrl.sv */
// ----------------------------------------------------------------------------
// bsl_ctrl
// Command sequencer: keeps the live count and search limit, drives the entry
// store with read-modify-write sequences and registers the result item.
// ----------------------------------------------------------------------------
module bsl_ctrl #(
    parameter int TABLE_DEPTH = bsl_pkg::DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = bsl_pkg::DEF_ENTRY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bsl_pkg::COUNT_W-1:0]     capacity,
    bsl_cmd_if.sink                         cmd,
    bsl_rsp_if.source                       rsp,
    output logic                            ram_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  ram_wr_addr,
    output logic [ENTRY_BITS-1:0]           ram_wr_data,
    output logic                            ram_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  ram_rd_addr,
    input  logic [ENTRY_BITS-1:0]           ram_rd_data
);
    import bsl_pkg::*;

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int MAX_COUNT = (1 << COUNT_W) - 1;
    // Largest count the store can hold, saturated to the count width.
    localparam logic [COUNT_W-1:0] DEPTH_SAT =
        COUNT_W'((TABLE_DEPTH > MAX_COUNT) ? MAX_COUNT : TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_SCAN,
        S_RESP
    } state_t;

    // Maps a count or position onto a store address of the right width.
    function automatic logic [AW-1:0] to_addr(input logic [COUNT_W-1:0] c);
        logic [COUNT_W+AW-1:0] w;
        w = {{AW{1'b0}}, c};
        return w[AW-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     limit_reg, limit_next;
    logic [COUNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [COUNT_W-1:0]     scan_end_reg, scan_end_next;
    logic [ENTRY_BITS-1:0]  val_reg, val_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    status_t                pend_status_reg, pend_status_next;
    logic                   pend_present_reg, pend_present_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    status_t                rsp_status_reg, rsp_status_next;
    logic [COUNT_W-1:0]     rsp_count_reg, rsp_count_next;
    logic                   rsp_present_reg, rsp_present_next;

    logic [COUNT_W-1:0]         eff_cap;
    logic                       push_ok;
    logic [ENTRY_BITS-1:0]      cmd_val;
    logic [VALUE_W+ENTRY_BITS-1:0] cmd_val_wide;
    logic [COUNT_W-1:0]         cmd_pos;
    logic [COUNT_W-1:0]         last_idx;
    logic [COUNT_W-1:0]         union_lim;

    // Effective capacity and the item value fitted to the entry width.
    assign eff_cap      = (capacity < DEPTH_SAT) ? capacity : DEPTH_SAT;
    assign push_ok      = count_reg < eff_cap;
    assign cmd_val_wide = {{ENTRY_BITS{1'b0}}, cmd.item_value};
    assign cmd_val      = cmd_val_wide[ENTRY_BITS-1:0];
    assign cmd_pos      = {{(COUNT_W-POS_W){1'b0}}, cmd.position};
    assign last_idx     = count_reg - 1'b1;

    // Search bound of a union item: frozen limit clipped to the live count.
    always_comb
    begin
        if (cmd.batch_start)
        begin
            union_lim = count_reg;
        end
        else
        begin
            union_lim = (limit_reg < count_reg) ? limit_reg : count_reg;
        end
    end

    assign cmd.ready = (state_reg == S_IDLE);

    // Next-state logic and store access sequencing.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        limit_next        = limit_reg;
        scan_idx_next     = scan_idx_reg;
        scan_end_next     = scan_end_reg;
        val_next          = val_reg;
        pos_next          = pos_reg;
        pend_status_next  = pend_status_reg;
        pend_present_next = pend_present_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_status_next   = rsp_status_reg;
        rsp_count_next    = rsp_count_reg;
        rsp_present_next  = rsp_present_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = to_addr(count_reg);
        ram_wr_data       = val_reg;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next          = cmd_val;
                    pos_next          = cmd.position;
                    pend_status_next  = ST_OK;
                    pend_present_next = 1'b0;
                    state_next        = S_RESP;
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (push_ok)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = cmd_val;
                                count_next  = count_reg + 1'b1;
                            end
                            else
                            begin
                                pend_status_next = ST_OVERRUN;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (cmd_pos < count_reg)
                            begin
                                count_next = last_idx;
                                // Fill the hole with the last entry.
                                if (cmd_pos != last_idx)
                                begin
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = to_addr(last_idx);
                                    state_next  = S_MOVE;
                                end
                            end
                            else if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pend_status_next = ST_RANGE;
                            end
                        end
                        CMD_UNION:
                        begin
                            if (cmd.batch_start)
                            begin
                                limit_next = count_reg;
                            end
                            if (union_lim == '0)
                            begin
                                // Nothing to compare against: insert now.
                                if (push_ok)
                                begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_data = cmd_val;
                                    count_next  = count_reg + 1'b1;
                                end
                                else
                                begin
                                    pend_status_next = ST_OVERRUN;
                                end
                            end
                            else
                            begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = '0;
                                scan_idx_next = 7'd1;
                                scan_end_next = union_lim;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end

            S_MOVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = to_addr({{(COUNT_W-POS_W){1'b0}}, pos_reg});
                ram_wr_data = ram_rd_data;
                state_next  = S_RESP;
            end

            S_SCAN:
            begin
                // Read data holds the entry at scan_idx_reg - 1.
                if (ram_rd_data == val_reg)
                begin
                    pend_present_next = 1'b1;
                    state_next        = S_RESP;
                end
                else if (scan_idx_reg == scan_end_reg)
                begin
                    if (push_ok)
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_OVERRUN;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = to_addr(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                // Load the output register once it is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = pend_status_reg;
                    rsp_count_next   = count_reg;
                    rsp_present_next = pend_present_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            limit_reg        <= '0;
            scan_idx_reg     <= '0;
            scan_end_reg     <= '0;
            val_reg          <= '0;
            pos_reg          <= '0;
            pend_status_reg  <= ST_OK;
            pend_present_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_status_reg   <= ST_OK;
            rsp_count_reg    <= '0;
            rsp_present_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            limit_reg        <= limit_next;
            scan_idx_reg     <= scan_idx_next;
            scan_end_reg     <= scan_end_next;
            val_reg          <= val_next;
            pos_reg          <= pos_next;
            pend_status_reg  <= pend_status_next;
            pend_present_reg <= pend_present_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_status_reg   <= rsp_status_next;
            rsp_count_reg    <= rsp_count_next;
            rsp_present_reg  <= rsp_present_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.was_present = rsp_present_reg;

`ifndef SYNTHESIS
    // The live count never exceeds what the store can hold.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_SAT)
        else $error("live count beyond store depth");

    // The scan stays within its frozen bound and the live entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= scan_end_reg &&
                                scan_end_reg <= count_reg)
        else $error("union scan outside its bound");

    // The store is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("store read and write overlap");

    // A new result item appears only out of the response state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result item raised outside response state");

    // A clear item empties the table.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.command == CMD_CLEAR |=> count_reg == '0)
        else $error("clear left entries in the table");
`endif

endmodule

/* src/bounded_set_list_table.sv */
// ----------------------------------------------------------------------------
// bounded_set_list_table
// Bounded table of entries with a live count: clear, append, swap-remove and
// union insert against a frozen search limit.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command item (clear, append, remove at position, union
//   insert); rsp returns exactly one result item per command with status,
//   entry count after the command and the was-present flag. Both channels
//   move an item when valid and ready are high at a rising clock edge.
//   The APB port holds the capacity register at byte address 0.
// Sequencing:
//   Items are processed one at a time. Clear, append and a remove that only
//   drops the count go straight to the response state; a remove that moves
//   the last entry first copies it into the hole. A union insert reads the
//   entry store one entry per cycle over the searched range of at most
//   TABLE_DEPTH entries, stopping at a hit, and inserts on a miss.
// Reset and stalls:
//   Reset clears the count, search limit and result register and sets the
//   capacity to 64; the entry store is not cleared, as only entries below
//   the count are read. A result item waits in the output register while
//   the receiver stalls and the next item is still taken; its own result
//   then holds until the output register is free.
// ----------------------------------------------------------------------------
module bounded_set_list_table #(
    parameter int TABLE_DEPTH = bsl_pkg::DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = bsl_pkg::DEF_ENTRY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bsl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bsl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bsl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    bsl_cmd_if.sink                         cmd,
    bsl_rsp_if.source                       rsp
);
    import bsl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0]     capacity;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [ENTRY_BITS-1:0]  ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [ENTRY_BITS-1:0]  ram_rd_data;

    // Configuration registers.
    bsl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Entry store.
    bsl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Command sequencer.
    bsl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity),
        .cmd         (cmd),
        .rsp         (rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule

/* tb/bounded_set_list_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_list_table_tb
// Self-checking bench for the bounded set/list table. A driver feeds command
// items from a queue filled by the stimulus process, and a shadow model of
// the entry store, live count, frozen search limit and capacity register
// predicts each result item. A monitor compares the result items in order.
// The run covers directed corner cases, then random phases under several
// capacity settings with random idling on both channels. It also includes one
// long receiver hold-off that backs the table up into its command input.
// ----------------------------------------------------------------------------
module bounded_set_list_table_tb;
    import bsl_pkg::*;

    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int POOL_SIZE      = 12;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 105;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 160;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = DEPTH + 16;
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * int'(REG_CAPACITY));

    typedef struct {
        cmd_code_t          command;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               batch_start;
    } table_cmd_t;

    typedef struct {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               present;
    } table_result_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bsl_cmd_if cmd_ch ();
    bsl_rsp_if rsp_ch ();

    bounded_set_list_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch)
    );

    // Command items waiting to be offered, and results owed by the table.
    table_cmd_t    cmds_waiting [$];
    table_result_t results_due [$];

    // Shadow copy of the table state and its capacity register.
    logic [VALUE_W-1:0] entries [DEPTH];
    int unsigned        shadow_count = 0;
    int unsigned        frozen_limit = 0;
    logic [COUNT_W-1:0] capacity_reg = CAPACITY_RESET;

    // Values that batches draw from, so that repeats and hits are frequent.
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int  fail_count   = 0;
    int  queued_total = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  calm         = 1'b0;

    // Coverage tallies for the closing summary.
    int n_clear = 0, n_append = 0, n_remove = 0, n_union = 0;
    int n_hit = 0, n_overrun = 0, n_empty = 0, n_range = 0;
    int unsigned peak_count = 0;

    // Clock: 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow table and returns the result it owes.
    function automatic table_result_t apply_command(table_cmd_t c);
        table_result_t r;
        int unsigned   cap;
        int unsigned   lim;
        r.status  = ST_OK;
        r.present = 1'b0;
        cap = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
        case (c.command)
            CMD_CLEAR:
            begin
                n_clear++;
                shadow_count = 0;
            end
            CMD_APPEND:
            begin
                n_append++;
                if (shadow_count < cap)
                begin
                    entries[shadow_count] = c.value;
                    shadow_count++;
                end
                else
                    r.status = ST_OVERRUN;
            end
            CMD_REMOVE:
            begin
                n_remove++;
                if (c.position < shadow_count)
                begin
                    // The last entry fills the hole unless it is the hole.
                    if (c.position != shadow_count - 1)
                        entries[c.position] = entries[shadow_count - 1];
                    shadow_count--;
                end
                else
                    r.status = (shadow_count == 0) ? ST_EMPTY : ST_RANGE;
            end
            default:
            begin
                n_union++;
                if (c.batch_start)
                    frozen_limit = shadow_count;
                lim = (frozen_limit < shadow_count) ? frozen_limit : shadow_count;
                for (int j = 0; j < lim; j++)
                    if (entries[j] == c.value)
                        r.present = 1'b1;
                if (r.present)
                    n_hit++;
                else if (shadow_count < cap)
                begin
                    entries[shadow_count] = c.value;
                    shadow_count++;
                end
                else
                    r.status = ST_OVERRUN;
            end
        endcase
        if (r.status == ST_OVERRUN)
            n_overrun++;
        if (r.status == ST_EMPTY)
            n_empty++;
        if (r.status == ST_RANGE)
            n_range++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Queues one command item for the driver.
    task automatic add_cmd(cmd_code_t command, logic [VALUE_W-1:0] value,
                           logic [POS_W-1:0] position, logic batch_start);
        table_cmd_t c;
        c.command     = command;
        c.value       = value;
        c.position    = position;
        c.batch_start = batch_start;
        cmds_waiting.push_back(c);
        queued_total++;
    endtask

    function automatic logic [VALUE_W-1:0] draw_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [POS_W-1:0] draw_position();
        if ($urandom_range(0, 1) == 1)
            return POS_W'($urandom());
        return POS_W'($urandom_range(0, 7));
    endfunction

    // Waits until no item is pending, on offer or owed.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmds_waiting.size() != 0 || cmd_ch.valid || results_due.size() != 0);
    endtask

    // Writes the capacity register, then reads it back.
    task automatic cap_write(logic [COUNT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_reg = value;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== APB_DATA_W'(value))
        begin
            $error("capacity_limit: expected %0d, got %0d", value, prdata);
            fail_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // One random phase: union batches, append and remove runs, clears and
    // noise, optionally opened by a run of appends that fills the table.
    task automatic queue_phase(int n_items, bit fill_first);
        int stop_at;
        int pick;
        int run;
        stop_at = queued_total + n_items;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            value_pool[k] = $urandom();
        if (fill_first)
            repeat (DEPTH + 6)
                add_cmd(CMD_APPEND, draw_value(), draw_position(), 1'($urandom()));
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // A batch mostly opens with a start flag; some do not.
                run = $urandom_range(2, 8);
                for (int k = 0; k < run; k++)
                    add_cmd(CMD_UNION, draw_value(), draw_position(),
                            (k == 0) && ($urandom_range(0, 7) != 0));
            end
            else if (pick < 65)
            begin
                run = $urandom_range(1, 6);
                repeat (run)
                    add_cmd(CMD_APPEND, draw_value(), draw_position(), 1'($urandom()));
            end
            else if (pick < 80)
            begin
                run = $urandom_range(1, 3);
                repeat (run)
                    add_cmd(CMD_REMOVE, draw_value(), draw_position(), 1'($urandom()));
            end
            else if (pick < 90)
                add_cmd(cmd_code_t'($urandom_range(0, 3)), $urandom(),
                        POS_W'($urandom()), 1'($urandom()));
            else if (pick < 92)
                add_cmd(CMD_CLEAR, draw_value(), draw_position(), 1'($urandom()));
            else
                add_cmd(CMD_UNION, draw_value(), draw_position(), 1'b0);
        end
    endtask

    // Driver: predicts on acceptance, then offers the next queued item.
    table_cmd_t on_offer;
    int         send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid       <= 1'b0;
            cmd_ch.command     <= CMD_CLEAR;
            cmd_ch.item_value  <= '0;
            cmd_ch.position    <= '0;
            cmd_ch.batch_start <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                results_due.push_back(apply_command(on_offer));
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 3);
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmds_waiting.size() != 0)
                begin
                    on_offer = cmds_waiting.pop_front();
                    cmd_ch.valid       <= 1'b1;
                    cmd_ch.command     <= on_offer.command;
                    cmd_ch.item_value  <= on_offer.value;
                    cmd_ch.position    <= on_offer.position;
                    cmd_ch.batch_start <= on_offer.batch_start;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result item and paces the ready line.
    table_result_t want;
    int            recv_gap  = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    $error("result item with nothing expected: status %0d, count %0d",
                           rsp_ch.status, rsp_ch.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, rsp_ch.entry_count);
                        fail_count++;
                    end
                    if (rsp_ch.was_present !== want.present)
                    begin
                        $error("was_present: expected %0d, got %0d",
                               want.present, rsp_ch.was_present);
                        fail_count++;
                    end
                end
            end
            // One long hold-off while the driver keeps offering items.
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 3);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("bounded_set_list_table: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus: directed corner cases, then random phases.
    logic [COUNT_W-1:0] phase_caps [PHASES] = '{7'd127, 7'd64, 7'd1, 7'd100,
                                                7'd0, 7'd40, 7'd64};
    bit                 phase_fill [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1,
                                                1'b0, 1'b0, 1'b1};

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty remove, union with no frozen limit, hits,
        // a batch that does not see its own additions, both kinds of
        // remove, out of range, and clear keeping the search limit.
        add_cmd(CMD_REMOVE, '0, '0, 1'b0);
        add_cmd(CMD_UNION, '0, '0, 1'b0);
        add_cmd(CMD_UNION, '0, '1, 1'b1);
        add_cmd(CMD_APPEND, '1, '0, 1'b0);
        add_cmd(CMD_APPEND, '1, '1, 1'b1);
        add_cmd(CMD_UNION, 32'h0000_1234, '0, 1'b1);
        add_cmd(CMD_UNION, 32'h0000_1234, '0, 1'b0);
        add_cmd(CMD_REMOVE, '0, 6'd4, 1'b0);
        add_cmd(CMD_REMOVE, '0, 6'd0, 1'b0);
        add_cmd(CMD_REMOVE, '0, 6'd63, 1'b0);
        add_cmd(CMD_UNION, 32'h0000_1234, '0, 1'b0);
        add_cmd(CMD_CLEAR, '1, '1, 1'b1);
        add_cmd(CMD_UNION, 32'd5, '0, 1'b0);
        add_cmd(CMD_UNION, 32'd5, '0, 1'b0);
        wait_idle();

        // Zero capacity: appends and absent unions overrun.
        cap_write(7'd0);
        add_cmd(CMD_APPEND, 32'd7, '0, 1'b0);
        add_cmd(CMD_UNION, 32'd9, '0, 1'b1);
        add_cmd(CMD_CLEAR, '0, '0, 1'b0);
        add_cmd(CMD_REMOVE, '0, '0, 1'b0);
        wait_idle();

        // Capacity of two: full table on append and union, hit when full.
        cap_write(7'd2);
        add_cmd(CMD_APPEND, 32'hA5A5_A5A5, '0, 1'b0);
        add_cmd(CMD_APPEND, 32'h5A5A_5A5A, '0, 1'b0);
        add_cmd(CMD_APPEND, 32'd3, '0, 1'b0);
        add_cmd(CMD_UNION, 32'd4, '0, 1'b1);
        add_cmd(CMD_UNION, 32'h5A5A_5A5A, '0, 1'b0);
        add_cmd(CMD_REMOVE, '0, 6'd1, 1'b0);
        wait_idle();

        // Random phases; the last runs without idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            cap_write(phase_caps[p]);
            if (p == PHASES - 1)
                calm = 1'b1;
            queue_phase(PHASE_ITEMS, phase_fill[p]);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d results never arrived", results_due.size());
            fail_count++;
        end

        $display("run covered %0d items: %0d clear, %0d append, %0d remove, %0d union",
                 queued_total, n_clear, n_append, n_remove, n_union);
        $display("union hits %0d, overruns %0d, empty %0d, out of range %0d, peak count %0d",
                 n_hit, n_overrun, n_empty, n_range, peak_count);
        if (fail_count == 0)
            $display("bounded_set_list_table: match");
        else
            $display("bounded_set_list_table: mismatch");
        $finish;
    end

endmodule
